### rtl/mips_subset_step_core_defines.svh
// assertion macros shared by the step core rtl
// expects signals named clk and rst in the module that uses them
`ifndef MIPS_SUBSET_STEP_CORE_DEFINES_SVH
`define MIPS_SUBSET_STEP_CORE_DEFINES_SVH

// same-cycle implication
`define MSSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MSSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/mssc_pkg.sv
// shared types and constants of the mips subset step core
// no dependencies
`default_nettype none

package mssc_pkg;

  localparam int ADDR_W = 11;
  localparam int DATA_W = 32;

  localparam logic [ADDR_W-1:0] REG_V0 = 11'd2;
  localparam logic [ADDR_W-1:0] REG_SP = 11'd29;
  localparam logic [ADDR_W-1:0] REG_RA = 11'd31;
  localparam logic [ADDR_W-1:0] REG_ZERO = 11'd0;
  localparam logic [DATA_W-1:0] STACK_INIT = 32'h0000_0800;
  localparam logic [DATA_W-1:0] EXIT_CODE = 32'd10;
  localparam logic [ADDR_W-1:0] ENTRY_PC_RESET = 11'd64;

  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_JAL = 6'h03;
  localparam logic [5:0] OP_BNE = 6'h05;
  localparam logic [5:0] OP_ADDIU = 6'h09;
  localparam logic [5:0] OP_LUI = 6'h0F;
  localparam logic [5:0] OP_SW = 6'h2B;

  localparam logic [5:0] FN_JR = 6'h08;
  localparam logic [5:0] FN_SYSCALL = 6'h0C;
  localparam logic [5:0] FN_ADDU = 6'h21;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_EXEC  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic [ADDR_W-1:0] fetch_next;
    logic [ADDR_W-1:0] seq_next;
    logic              halt;
  } exec_res_t;

  function automatic logic is_syscall(input logic [DATA_W-1:0] instr);
    return (instr[31:26] == OP_SPECIAL) && (instr[5:0] == FN_SYSCALL);
  endfunction

endpackage

`default_nettype wire

### rtl/mssc_ram.sv
// single-port word store, registered read
// words beyond the depth read as zero and ignore writes; uses mssc_pkg
`default_nettype none

module mssc_ram #(
  parameter int DEPTH = 2048
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [mssc_pkg::ADDR_W-1:0] addr,
  input  wire logic [mssc_pkg::DATA_W-1:0] wdata,
  output logic      [mssc_pkg::DATA_W-1:0] q
);
  import mssc_pkg::*;

  localparam int IW = $clog2(DEPTH);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd;
  logic              rd_ok;
  logic              in_range;

  assign in_range = ({1'b0, addr} < (ADDR_W + 1)'(DEPTH));

  always_ff @(posedge clk) begin
    if (we && in_range) begin
      mem[addr[IW-1:0]] <= wdata;
    end
    rd    <= mem[addr[IW-1:0]];
    rd_ok <= in_range;
  end

  assign q = rd_ok ? rd : '0;

endmodule

`default_nettype wire

### rtl/mssc_exec.sv
// instruction decode and execute for the step core
// computes writeback and next counters from the fetched word; uses mssc_pkg
`default_nettype none

module mssc_exec (
  input  wire logic [mssc_pkg::DATA_W-1:0] instr,
  input  wire logic [mssc_pkg::DATA_W-1:0] a,
  input  wire logic [mssc_pkg::DATA_W-1:0] b,
  input  wire logic [mssc_pkg::ADDR_W-1:0] seq,
  output mssc_pkg::exec_res_t              res
);
  import mssc_pkg::*;

  logic [5:0]        op;
  logic [5:0]        funct;
  logic [DATA_W-1:0] simm;
  logic [ADDR_W-1:0] s;
  logic [DATA_W-1:0] sum_ai;

  assign op     = instr[31:26];
  assign funct  = instr[5:0];
  assign simm   = {{16{instr[15]}}, instr[15:0]};
  assign s      = seq + 11'd1;
  assign sum_ai = a + simm;

  always_comb begin
    res            = '0;
    res.fetch_next = s;
    res.seq_next   = s;
    case (op)
      OP_SPECIAL: begin
        case (funct)
          FN_JR: begin
            res.seq_next = a[ADDR_W-1:0] - 11'd1;
          end
          // a carries register 2 here
          FN_SYSCALL: begin
            res.halt = (a == EXIT_CODE);
          end
          FN_ADDU: begin
            res.wr_en   = 1'b1;
            res.wr_addr = {6'd0, instr[15:11]};
            res.wr_data = a + b;
          end
          default: begin
            res.wr_en   = 1'b1;
            res.wr_addr = REG_ZERO;
            res.wr_data = '0;
          end
        endcase
      end
      OP_JAL: begin
        res.wr_en    = 1'b1;
        res.wr_addr  = REG_RA;
        res.wr_data  = {21'd0, s + 11'd1};
        res.seq_next = instr[ADDR_W-1:0] - 11'd1;
      end
      OP_BNE: begin
        if (a != b) begin
          res.seq_next = s + simm[ADDR_W-1:0] - 11'd1;
        end
      end
      OP_ADDIU: begin
        res.wr_en   = 1'b1;
        res.wr_addr = {6'd0, instr[20:16]};
        res.wr_data = sum_ai;
      end
      OP_LUI: begin
        res.wr_en   = 1'b1;
        res.wr_addr = {6'd0, instr[20:16]};
        res.wr_data = {instr[15:0], 16'd0};
      end
      OP_SW: begin
        res.wr_en   = 1'b1;
        res.wr_addr = {2'd0, sum_ai[10:2]};
        res.wr_data = b;
      end
      default: begin
        res.wr_en   = 1'b1;
        res.wr_addr = REG_ZERO;
        res.wr_data = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/mips_subset_step_core.sv
// Step core for a small mips subset over one word store (registers at words 0-31).
// Input stream s_*: tuser carries the command (start, execute, write word, read word),
// tdata carries address and data. Output stream m_*: one transaction per command with
// the read word, the fetch pointer after the command and the finished flag.
// cfg_*: entry_pc, always ready; user writes it while the core is idle, unchecked.
// States per command, acceptance to next acceptance, with the output register free:
//   start, write word, or execute after finish: done
//   read word: read, done
//   execute: fetch, rs read, rt read with writeback, done; all on the one store port
// m_tvalid rises as the core returns to idle, ready for the next command.
// The single store port serializes these steps; one command is worked at a time.
// A finished result waits in the output register while the next command is accepted;
// if the receiver stalls, that next command parks until the register frees.
// Reset clears counters and flags and then sweeps zeros through store words 0 to
// MEM_WORDS-1, one word a cycle, s_tready low; cfg writes are taken during the sweep.
// Depends on mssc_pkg, mssc_ram, mssc_exec and mips_subset_step_core_defines.svh.
`include "mips_subset_step_core_defines.svh"
`default_nettype none

module mips_subset_step_core #(
  parameter int MEM_WORDS = 2048
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // cfg_data: entry_pc
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [10:0] cfg_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // s_tdata: address [10:0], data [42:11], zero fill [47:43]
  input  wire logic [47:0] s_tdata,
  // s_tuser: cmd [1:0]
  input  wire logic [1:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // m_tdata: read_data [31:0], fetch_address [42:32], finished [43], zero fill [47:44]
  output logic      [47:0] m_tdata
);
  import mssc_pkg::*;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_READ  = 7'b0000100,
    ST_INSTR = 7'b0001000,
    ST_REGA  = 7'b0010000,
    ST_REGB  = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  state_t            state;
  logic [ADDR_W-1:0] clr_cnt;
  logic [ADDR_W-1:0] entry_pc;
  logic [ADDR_W-1:0] fp;
  logic [ADDR_W-1:0] seq;
  logic              halted;
  logic [DATA_W-1:0] instr;
  logic [DATA_W-1:0] a_reg;
  logic [DATA_W-1:0] rdata;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [DATA_W-1:0] ram_wdata;
  logic [DATA_W-1:0] ram_q;

  logic              in_acc;
  cmd_t              in_cmd;
  logic [ADDR_W-1:0] in_address;
  logic [DATA_W-1:0] in_data;
  logic              out_free;
  exec_res_t         ex;

  assign s_tready   = (state == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign in_acc     = s_tvalid && s_tready;
  assign in_cmd     = cmd_t'(s_tuser);
  assign in_address = s_tdata[10:0];
  assign in_data    = s_tdata[42:11];
  assign out_free   = !m_tvalid || m_tready;

  mssc_ram #(
    .DEPTH(MEM_WORDS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .q    (ram_q)
  );

  mssc_exec u_exec (
    .instr(instr),
    .a    (a_reg),
    .b    (ram_q),
    .seq  (seq),
    .res  (ex)
  );

  // store port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = fp;
    ram_wdata = '0;
    case (state)
      ST_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_cnt;
      end
      ST_IDLE: begin
        if (in_acc) begin
          case (in_cmd)
            CMD_START: begin
              ram_we    = 1'b1;
              ram_addr  = REG_SP;
              ram_wdata = STACK_INIT;
            end
            CMD_EXEC: begin
              ram_addr = fp;
            end
            CMD_WRITE: begin
              ram_we    = 1'b1;
              ram_addr  = in_address;
              ram_wdata = in_data;
            end
            CMD_READ: begin
              ram_addr = in_address;
            end
            default: begin
              ram_addr = fp;
            end
          endcase
        end
      end
      // syscall tests register 2 in place of rs
      ST_INSTR: begin
        ram_addr = is_syscall(ram_q) ? REG_V0 : {6'd0, ram_q[25:21]};
      end
      ST_REGA: begin
        ram_addr = {6'd0, instr[20:16]};
      end
      ST_REGB: begin
        ram_we    = ex.wr_en;
        ram_addr  = ex.wr_addr;
        ram_wdata = ex.wr_data;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_cnt  <= '0;
      entry_pc <= ENTRY_PC_RESET;
      fp       <= '0;
      seq      <= '0;
      halted   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        entry_pc <= cfg_data;
      end
      if (m_tready && !((state == ST_DONE) && out_free)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 11'd1;
          if (clr_cnt == ADDR_W'(MEM_WORDS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            rdata <= '0;
            case (in_cmd)
              CMD_START: begin
                fp     <= entry_pc;
                seq    <= entry_pc;
                halted <= 1'b0;
                state  <= ST_DONE;
              end
              CMD_EXEC: begin
                state <= halted ? ST_DONE : ST_INSTR;
              end
              CMD_WRITE: begin
                state <= ST_DONE;
              end
              CMD_READ: begin
                state <= ST_READ;
              end
              default: begin
                state <= ST_DONE;
              end
            endcase
          end
        end
        ST_READ: begin
          rdata <= ram_q;
          state <= ST_DONE;
        end
        ST_INSTR: begin
          instr <= ram_q;
          state <= ST_REGA;
        end
        ST_REGA: begin
          a_reg <= ram_q;
          state <= ST_REGB;
        end
        ST_REGB: begin
          fp    <= ex.fetch_next;
          seq   <= ex.seq_next;
          state <= ST_DONE;
          if (ex.halt) begin
            halted <= 1'b1;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {4'd0, halted, fp, rdata};
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `MSSC_ASSERT_NEXT(a_halt_only_exec, !halted && (state != ST_REGB), !halted,
                    "halted set outside execute")
  `MSSC_ASSERT_NEXT(a_out_only_done, !m_tvalid && (state != ST_DONE), !m_tvalid,
                    "output valid without a finished command")
  `MSSC_ASSERT_NEXT(a_fp_stable, (state != ST_IDLE) && (state != ST_REGB), $stable(fp),
                    "fetch pointer moved outside start or execute")
  `MSSC_ASSERT_NOW(a_no_write_in_fetch,
                   (state == ST_INSTR) || (state == ST_REGA) || (state == ST_READ),
                   !ram_we, "store written during a read phase")

endmodule

`default_nettype wire
